>>> sv/slm_pkg.sv
package slm_pkg;

    // Fixed field widths
    localparam int COORD_W     = 12;
    localparam int LEVEL_W     = 8;
    localparam int COT_W       = 16;
    localparam int INV_W       = 24;
    localparam int OFFSET_W    = 20;
    localparam int CFG_DATA_W  = 24;

    // Fixed point: phase numerator in Q.12, fraction in Q0.32
    localparam int FRAC_BITS   = 12;
    localparam int PHASE_W     = 32;
    localparam int CY_W        = COT_W + COORD_W;

    // Views 0..OPEN_VIEWS-1 are open, the rest dark
    localparam int NUM_VIEWS_DEFAULT = 6;
    localparam int OPEN_VIEWS        = 3;
    localparam int SUBPIXELS         = 3;
    localparam int STAGES            = 5;

    localparam logic [LEVEL_W-1:0] LEVEL_OPEN = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_DARK = 8'd0;

    // Register reset values
    localparam logic [COT_W-1:0]    COT_RESET    = 16'd1229;
    localparam logic [INV_W-1:0]    INV_RESET    = 24'd1747627;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 20'd0;
    localparam logic                SLOPE_RESET  = 1'b1;

    typedef enum logic [1:0] {
        CFG_COT_MAGNITUDE = 2'd0,
        CFG_INV_COVER     = 2'd1,
        CFG_PHASE_OFFSET  = 2'd2,
        CFG_SLOPE_MODE    = 2'd3
    } slm_cfg_idx_t;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } slm_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } slm_out_t;

    // Stage load enables handed to the per-subpixel datapath
    typedef struct packed {
        logic ld_frac;
        logic ld_view;
    } slm_adv_t;

endpackage

>>> sv/slm_subpixel.sv
module slm_subpixel
    import slm_pkg::*;
#(
    parameter int NUM_VIEWS = NUM_VIEWS_DEFAULT
)
(
    input  logic                clk,
    input  slm_adv_t            adv,
    input  logic [INV_W-1:0]    inv_cover,
    input  logic [PHASE_W-1:0]  num,
    output logic [LEVEL_W-1:0]  level
);

    localparam int VIEW_W  = $clog2(NUM_VIEWS);
    localparam int SCALE_W = PHASE_W + VIEW_W;

    logic [PHASE_W+INV_W-1:0] prod;
    logic [PHASE_W-1:0]       frac_next;
    logic [PHASE_W-1:0]       frac_reg;
    logic [SCALE_W-1:0]       scaled;
    logic [VIEW_W-1:0]        view_next;
    logic [VIEW_W-1:0]        view_reg;
    logic [PHASE_W-1:0]       t_next;
    logic [PHASE_W-1:0]       t_reg;
    logic [VIEW_W-1:0]        view_up;
    logic                     a_open;
    logic                     b_open;
    logic [PHASE_W:0]         t_rem;
    logic [PHASE_W+LEVEL_W:0] fall_prod;
    logic [PHASE_W+LEVEL_W-1:0] rise_prod;

    // Phase fraction: keep the low 32 bits of numerator times reciprocal
    assign prod      = {{INV_W{1'b0}}, num} * {{PHASE_W{1'b0}}, inv_cover};
    assign frac_next = prod[PHASE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv.ld_frac)
        begin
            frac_reg <= frac_next;
        end
    end

    // Scale by view count: integer part is the view, the rest the blend weight
    assign scaled    = {{VIEW_W{1'b0}}, frac_reg} * SCALE_W'(NUM_VIEWS);
    assign view_next = scaled[SCALE_W-1:PHASE_W];
    assign t_next    = scaled[PHASE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv.ld_view)
        begin
            view_reg <= view_next;
            t_reg    <= t_next;
        end
    end

    // Blend between this view and the next, wrapping at the last view
    assign view_up   = (view_reg == VIEW_W'(NUM_VIEWS - 1)) ? '0 : view_reg + 1'b1;
    assign a_open    = view_reg < VIEW_W'(OPEN_VIEWS);
    assign b_open    = view_up < VIEW_W'(OPEN_VIEWS);
    assign t_rem     = {1'b1, {PHASE_W{1'b0}}} - {1'b0, t_reg};
    assign fall_prod = {{LEVEL_W{1'b0}}, t_rem} * (PHASE_W+LEVEL_W+1)'(LEVEL_OPEN);
    assign rise_prod = {{LEVEL_W{1'b0}}, t_reg} * (PHASE_W+LEVEL_W)'(LEVEL_OPEN);

    always_comb
    begin
        if (a_open == b_open)
        begin
            level = a_open ? LEVEL_OPEN : LEVEL_DARK;
        end
        else if (a_open)
        begin
            level = fall_prod[PHASE_W+LEVEL_W-1:PHASE_W];
        end
        else
        begin
            level = rise_prod[PHASE_W+LEVEL_W-1:PHASE_W];
        end
    end

endmodule

>>> sv/slanted_lens_subpixel_mask.sv
// Slanted-lens subpixel mask: takes one pixel (column, row) per beat and
// returns its red, green and blue mask levels, 0 dark to 255 open. The block
// accepts one pixel every clock unless in_stall holds the input back, and
// each result passes through five register stages (coordinate terms, phase
// numerator, reciprocal multiply, view scaling, blend and output).
// A stalled output holds its beat while empty stages upstream keep filling.
// The user must write registers through cfg_wr_en / cfg_index / cfg_data
// only while no pixel is in flight; the block itself does not enforce this.
module slanted_lens_subpixel_mask
    import slm_pkg::*;
#(
    parameter int NUM_VIEWS = NUM_VIEWS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  slm_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output slm_out_t              out_data,
    input  logic                  cfg_wr_en,
    input  slm_cfg_idx_t          cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [COT_W-1:0]    cot_magnitude_reg;
    logic [INV_W-1:0]    inv_cover_reg;
    logic [OFFSET_W-1:0] phase_offset_reg;
    logic                slope_mode_reg;

    logic [STAGES-1:0]   v_reg;
    logic [STAGES-1:0]   rdy;
    logic [STAGES-2:0]   lsb_reg;

    logic [CY_W-1:0]     cy_next;
    logic [CY_W-1:0]     cy_reg;
    logic [PHASE_W-1:0]  base_next;
    logic [PHASE_W-1:0]  base_reg;
    logic [CY_W+1:0]     cy3;
    logic [PHASE_W-1:0]  num_next [SUBPIXELS];
    logic [PHASE_W-1:0]  num_reg  [SUBPIXELS];
    logic [LEVEL_W-1:0]  lvl      [SUBPIXELS];
    logic [LEVEL_W-1:0]  vert_lvl;
    slm_adv_t            adv;
    slm_out_t            out_next;
    slm_out_t            out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cot_magnitude_reg <= COT_RESET;
            inv_cover_reg     <= INV_RESET;
            phase_offset_reg  <= OFFSET_RESET;
            slope_mode_reg    <= SLOPE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_COT_MAGNITUDE: cot_magnitude_reg <= cfg_data[COT_W-1:0];
                CFG_INV_COVER:     inv_cover_reg     <= cfg_data[INV_W-1:0];
                CFG_PHASE_OFFSET:  phase_offset_reg  <= cfg_data[OFFSET_W-1:0];
                CFG_SLOPE_MODE:    slope_mode_reg    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Stage ready chain: a stage loads when empty or when it drains
    always_comb
    begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = v_reg[STAGES-1];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Carry the column parity for vertical mode
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            lsb_reg[0] <= in_data.column[0];
        end
        for (int i = 1; i < STAGES - 1; i++)
        begin
            if (rdy[i])
            begin
                lsb_reg[i] <= lsb_reg[i-1];
            end
        end
    end

    // Stage 1: slope term c*y and column term 3*x*4096 + offset
    assign cy_next   = {{COORD_W{1'b0}}, cot_magnitude_reg} * {{COT_W{1'b0}}, in_data.row};
    assign base_next = (PHASE_W'({2'b00, in_data.column} * 14'd3) << FRAC_BITS)
                     + {{(PHASE_W-OFFSET_W){phase_offset_reg[OFFSET_W-1]}}, phase_offset_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            cy_reg   <= cy_next;
            base_reg <= base_next;
        end
    end

    // Stage 2: per-subpixel numerator, modulo 2^32
    assign cy3 = {1'b0, cy_reg, 1'b0} + {2'b00, cy_reg};

    always_comb
    begin
        for (int k = 0; k < SUBPIXELS; k++)
        begin
            num_next[k] = base_reg + (PHASE_W'(k) << FRAC_BITS) - PHASE_W'(cy3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int k = 0; k < SUBPIXELS; k++)
            begin
                num_reg[k] <= num_next[k];
            end
        end
    end

    // Stages 3 and 4: reciprocal multiply and view scaling per subpixel
    assign adv.ld_frac = rdy[2];
    assign adv.ld_view = rdy[3];

    for (genvar k = 0; k < SUBPIXELS; k++)
    begin : g_sub
        slm_subpixel #(
            .NUM_VIEWS (NUM_VIEWS)
        ) u_subpixel (
            .clk       (clk),
            .adv       (adv),
            .inv_cover (inv_cover_reg),
            .num       (num_reg[k]),
            .level     (lvl[k])
        );
    end

    // Stage 5: pick slanted or vertical levels and hold the output beat
    assign vert_lvl = lsb_reg[STAGES-2] ? LEVEL_DARK : LEVEL_OPEN;

    always_comb
    begin
        if (slope_mode_reg)
        begin
            out_next.red_level   = lvl[2];
            out_next.green_level = lvl[1];
            out_next.blue_level  = lvl[0];
        end
        else
        begin
            out_next.red_level   = vert_lvl;
            out_next.green_level = vert_lvl;
            out_next.blue_level  = vert_lvl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[STAGES-1])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

>>> sv/slm_check.sv
module slm_check
    import slm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input slm_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input slm_out_t out_data
);

    // A stalled result beat stays and holds its levels
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // With the output drained, the input side never stalls
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output");

    // An accepted pixel reaches the output if the output side does not stall meanwhile
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid)
        else $error("accepted pixel did not reach the output");

endmodule

bind slanted_lens_subpixel_mask slm_check u_slm_check (.*);

>>> tb/slanted_lens_subpixel_mask_tb.sv
module slanted_lens_subpixel_mask_tb;
    import slm_pkg::*;

    localparam int VIEW_COUNT      = NUM_VIEWS_DEFAULT;
    localparam int DRAIN_CYCLES    = STAGES + 4;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 12;
    localparam int PIXELS_PER_PHASE = 137;
    localparam int MAX_PRINTED     = 100;

    // Expected mask levels, computed from a private copy of the registers
    class mask_scoreboard;
        logic [COT_W-1:0]    cot_mag;
        logic [INV_W-1:0]    inv_pitch;
        logic [OFFSET_W-1:0] offset;
        bit                  slope;
        slm_out_t            levels_q[$];
        int                  errors;

        function new();
            cot_mag   = COT_RESET;
            inv_pitch = INV_RESET;
            offset    = OFFSET_RESET;
            slope     = SLOPE_RESET;
            errors    = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH: %s", msg);
        endtask

        function void set_register(slm_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COT_MAGNITUDE: cot_mag   = data[COT_W-1:0];
                CFG_INV_COVER:     inv_pitch = data[INV_W-1:0];
                CFG_PHASE_OFFSET:  offset    = data[OFFSET_W-1:0];
                CFG_SLOPE_MODE:    slope     = data[0];
                default: ;
            endcase
        endfunction

        // Lens phase -> view -> blended level for one subpixel
        function logic [LEVEL_W-1:0] subpixel_level(logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y, int k);
            longint      numer;
            logic [63:0] prod;
            logic [63:0] scaled;
            logic [31:0] t;
            longint unsigned view;
            bit          a_open;
            bit          b_open;
            numer  = 3 * longint'(x) * 4096 + longint'($signed(offset))
                   + longint'(k) * 4096 - 3 * longint'(cot_mag) * longint'(y);
            prod   = numer * longint'(inv_pitch);
            scaled = {32'd0, prod[31:0]} * 64'(VIEW_COUNT);
            view   = 64'(scaled[63:32]);
            t      = scaled[31:0];
            a_open = view < OPEN_VIEWS;
            b_open = ((view + 1) % VIEW_COUNT) < OPEN_VIEWS;
            if (a_open == b_open)
                return a_open ? LEVEL_OPEN : LEVEL_DARK;
            if (a_open)
                return LEVEL_W'((64'd255 * (64'h1_0000_0000 - 64'(t))) >> 32);
            return LEVEL_W'((64'd255 * 64'(t)) >> 32);
        endfunction

        function void note_pixel(slm_in_t px);
            slm_out_t lv;
            if (slope)
            begin
                lv.red_level   = subpixel_level(px.column, px.row, 2);
                lv.green_level = subpixel_level(px.column, px.row, 1);
                lv.blue_level  = subpixel_level(px.column, px.row, 0);
            end
            else
            begin
                lv.red_level   = px.column[0] ? LEVEL_DARK : LEVEL_OPEN;
                lv.green_level = lv.red_level;
                lv.blue_level  = lv.red_level;
            end
            levels_q.push_back(lv);
        endfunction

        task check_levels(slm_out_t got);
            slm_out_t want;
            if (levels_q.size() == 0)
            begin
                report($sformatf("unexpected result beat %h", got));
                return;
            end
            want = levels_q.pop_front();
            if (got.red_level !== want.red_level)
                report($sformatf("red level %0d, expected %0d",
                                 got.red_level, want.red_level));
            if (got.green_level !== want.green_level)
                report($sformatf("green level %0d, expected %0d",
                                 got.green_level, want.green_level));
            if (got.blue_level !== want.blue_level)
                report($sformatf("blue level %0d, expected %0d",
                                 got.blue_level, want.blue_level));
        endtask

        function int pending();
            return levels_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    slm_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    slm_out_t              out_data;
    logic                  cfg_wr_en = 1'b0;
    slm_cfg_idx_t          cfg_index = CFG_COT_MAGNITUDE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    mask_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    slanted_lens_subpixel_mask #(.NUM_VIEWS(VIEW_COUNT)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Note accepted pixel beats and check accepted result beats
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_pixel(in_data);
        if (rst_n && out_valid && !out_stall)
            sb.check_levels(out_data);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic slm_in_t pix(int col, int row);
        slm_in_t p;
        p.column = COORD_W'(col);
        p.row    = COORD_W'(row);
        return p;
    endfunction

    // Mostly full-range coordinates, now and then an edge value
    function automatic slm_in_t random_pixel();
        slm_in_t p;
        p.column = COORD_W'($urandom_range(0, 4095));
        p.row    = COORD_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) == 0)
            p.column = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        if ($urandom_range(0, 9) == 0)
            p.row = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        return p;
    endfunction

    // Present one pixel beat, idling first at random, and hold it until taken
    task automatic send_pixel(slm_in_t px);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        // Let the monitor note a beat accepted at this same edge
        @(posedge clk);
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
            sb.report($sformatf("%0d pixels never produced levels", sb.pending()));
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers on consecutive edges; block must be idle
    task automatic configure(logic [COT_W-1:0] cot, logic [INV_W-1:0] inv,
                             logic [OFFSET_W-1:0] off, bit slope);
        logic [CFG_DATA_W-1:0] vals[4];
        slm_cfg_idx_t          idx;
        vals[0] = CFG_DATA_W'(cot);
        vals[1] = inv;
        vals[2] = CFG_DATA_W'(off);
        vals[3] = CFG_DATA_W'(slope);
        cfg_wr_en <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            idx = slm_cfg_idx_t'(i);
            cfg_index <= idx;
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_register(idx, vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 53;

        // Reset settings, frame corners and two inner pixels
        send_pixel(pix(0, 0));
        send_pixel(pix(4095, 0));
        send_pixel(pix(0, 4095));
        send_pixel(pix(4095, 4095));
        send_pixel(pix(1, 1));
        send_pixel(pix(2048, 1024));
        drain();

        // Vertical mode: even columns open, odd dark
        configure(COT_RESET, INV_RESET, OFFSET_RESET, 1'b0);
        send_pixel(pix(0, 5));
        send_pixel(pix(1, 5));
        send_pixel(pix(4094, 4095));
        send_pixel(pix(4095, 0));
        drain();

        // Zero reciprocal: phase stays zero, every level open
        configure(16'hFFFF, 24'd0, 20'h7FFFF, 1'b1);
        send_pixel(pix(4095, 4095));
        send_pixel(pix(3, 7));
        drain();

        // Largest reciprocal, no slope, most negative offset
        configure(16'd0, 24'hFFFFFF, 20'h80000, 1'b1);
        send_pixel(pix(0, 0));
        send_pixel(pix(4095, 4095));
        send_pixel(pix(100, 200));
        drain();

        // Smallest nonzero reciprocal, steepest slope
        configure(16'hFFFF, 24'd1, 20'd0, 1'b1);
        send_pixel(pix(4095, 4095));
        send_pixel(pix(0, 4095));
        drain();

        // Default lens, sweep columns across the view transitions
        configure(COT_RESET, INV_RESET, OFFSET_RESET, SLOPE_RESET);
        for (int c = 0; c < 6; c++)
            send_pixel(pix(c, 0));
        drain();

        // Random settings per phase, idling pattern changes every four phases
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            logic [COT_W-1:0]    cot;
            logic [INV_W-1:0]    inv;
            logic [OFFSET_W-1:0] off;
            bit                  slope;
            if (phase < 4)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 53;
            end
            else if (phase < 8)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(0, 3))
                0:       cot = '0;
                1:       cot = '1;
                default: cot = COT_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       inv = 24'd0;
                1:       inv = 24'd1;
                2:       inv = '1;
                3:       inv = INV_W'($urandom_range(1, 4096));
                default: inv = INV_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       off = 20'h80000;
                1:       off = 20'h7FFFF;
                default: off = OFFSET_W'($urandom);
            endcase
            slope = ($urandom_range(0, 4) != 0);
            configure(cot, inv, off, slope);
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                // Hold the sender mid-phase until the pipe empties
                if (i == PIXELS_PER_PHASE / 2)
                    drain();
                send_pixel(random_pixel());
            end
            drain();
        end

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
